// ===== rtl/bcde_pkg.sv =====
// Shared constants, codes and types of the binary cross dilate/erode block.
// No dependencies; the top level and the window refer to this package.
`timescale 1ns / 1ps

package bcde_pkg;

   // Default frame limits handed to the top level parameters
   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 1024;

   // Width of the frame size registers
   localparam int SIZE_W = 11;

   // Register indexes (word address bits of the configuration port)
   localparam logic [1:0] REG_MODE         = 2'd0;
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

   // Register reset values
   localparam logic              MODE_RESET         = 1'b0;
   localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET  = 11'd1024;
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = 11'd1024;

   // Operation codes
   localparam logic MODE_DILATE = 1'b0;
   localparam logic MODE_ERODE  = 1'b1;

   // Input item kinds
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_PAD   = 1'b1;

   // Per-step stencil control handed from the position logic to the window
   typedef struct packed {
      logic has_res;  // this step completes a result
      logic in_up;    // upper neighbor lies inside the frame
      logic in_dn;    // lower neighbor lies inside the frame
      logic in_lf;    // left neighbor lies inside the frame
      logic in_rt;    // right neighbor lies inside the frame
      logic last;     // result is the final one of the frame
   } flags_type;

endpackage

// ===== rtl/bcde_req_if.sv =====
// Input channel of the block: valid/ready handshake with one pixel transaction.
// Depends on nothing.
`timescale 1ns / 1ps

interface bcde_req_if;
   logic valid;
   logic ready;
   logic req_type;
   logic pixel;

   modport source (output valid, output req_type, output pixel, input ready);
   modport sink   (input valid, input req_type, input pixel, output ready);
endinterface

// ===== rtl/bcde_rsp_if.sv =====
// Result channel of the block: valid/ready handshake with one result transaction.
// Depends on nothing.
`timescale 1ns / 1ps

interface bcde_rsp_if;
   logic valid;
   logic ready;
   logic result_pixel;
   logic frame_last;

   modport source (output valid, output result_pixel, output frame_last, input ready);
   modport sink   (input valid, input result_pixel, input frame_last, output ready);
endinterface

// ===== rtl/binary_cross_dilate_erode.sv =====
// Binary dilation/erosion with a four-neighbor cross over a raster stream.
// A result transaction passes the step register and then the output register after the
// item that completes it is accepted (one row plus one pixel later in the stream).
// Throughput: one item per cycle while the result channel takes results, set by the single read port of each line cell.
// Reset clears position, window, pipeline and registers; line stores keep contents.
// Depends on bcde_pkg, bcde_req_if, bcde_rsp_if, bcde_line_cell and bcde_window.
`timescale 1ns / 1ps

module binary_cross_dilate_erode #(
   parameter int MAX_WIDTH  = bcde_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = bcde_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   bcde_req_if.sink    req_if,
   bcde_rsp_if.source  rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int SW  = bcde_pkg::SIZE_W;
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int RW  = $clog2(MAX_HEIGHT + 2);
   localparam int CMW = (WW > SW) ? WW : SW;
   localparam int CMH = (HW > SW) ? HW : SW;

   // Configuration registers
   logic          mode_ff;
   logic [SW-1:0] fw_ff;
   logic [SW-1:0] fh_ff;
   logic          cfg_wr;
   logic          size_wr;

   // Position and pipeline
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic          s1_valid_ff;
   logic          s1_val_ff;
   logic [CW-1:0] s1_col_ff;
   bcde_pkg::flags_type s1_flags_ff;
   logic          out_valid_ff;
   logic          out_pixel_ff;
   logic          out_last_ff;

   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [CMW-1:0] fw_ext;
   logic [CMH-1:0] fh_ext;
   logic          accept;
   logic          process;
   logic          row_in_frame;
   logic          col_ge1;
   logic          col_wrap;
   logic [RW-1:0] prow;
   logic          val;
   bcde_pkg::flags_type flags;
   logic          s1_adv;
   logic          out_take;
   logic          mid_old;
   logic          up_old;
   logic          win_pixel;
   logic          win_last;

   // Decode configuration writes
   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite && pready;
   assign size_wr = cfg_wr && ((paddr[3:2] == bcde_pkg::REG_FRAME_WIDTH)
                               || (paddr[3:2] == bcde_pkg::REG_FRAME_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bcde_pkg::MODE_RESET;
         fw_ff   <= bcde_pkg::FRAME_WIDTH_RESET;
         fh_ff   <= bcde_pkg::FRAME_HEIGHT_RESET;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            bcde_pkg::REG_MODE:         mode_ff <= pwdata[0];
            bcde_pkg::REG_FRAME_WIDTH:  fw_ff   <= pwdata[SW-1:0];
            bcde_pkg::REG_FRAME_HEIGHT: fh_ff   <= pwdata[SW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Return register contents on reads
   always_comb begin
      case (paddr[3:2])
         bcde_pkg::REG_MODE:         prdata = {31'd0, mode_ff};
         bcde_pkg::REG_FRAME_WIDTH:  prdata = {{(32 - SW){1'b0}}, fw_ff};
         bcde_pkg::REG_FRAME_HEIGHT: prdata = {{(32 - SW){1'b0}}, fh_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   // Clamp the frame size into one pixel up to the maximum
   assign fw_ext = CMW'(fw_ff);
   assign fh_ext = CMH'(fh_ff);

   always_comb begin
      if (fw_ff == '0) begin
         w_eff = WW'(1);
      end else if (fw_ext > CMW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(fw_ext);
      end
      if (fh_ff == '0) begin
         h_eff = HW'(1);
      end else if (fh_ext > CMH'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(fh_ext);
      end
   end

   // Classify the incoming transaction and derive the stencil borders
   assign s1_adv  = s1_valid_ff && (!s1_flags_ff.has_res || !out_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_adv;
   assign accept  = req_if.valid && req_if.ready;

   assign row_in_frame = RW'(h_eff) > row_ff;
   assign process  = !(row_in_frame && (req_if.req_type == bcde_pkg::REQ_PAD));
   assign val      = row_in_frame && req_if.pixel;
   assign col_ge1  = col_ff != '0;
   assign col_wrap = (WW'(col_ff) + WW'(1)) >= w_eff;
   assign prow     = col_ge1 ? row_ff : row_ff - RW'(1);

   always_comb begin
      flags.has_res = (row_ff >= RW'(2)) || ((row_ff == RW'(1)) && col_ge1);
      flags.in_up   = prow >= RW'(2);
      flags.in_dn   = prow < RW'(h_eff);
      flags.in_lf   = col_ge1 ? (WW'(col_ff) >= WW'(2)) : (w_eff >= WW'(2));
      flags.in_rt   = col_ge1;
      flags.last    = !col_ge1 && (row_ff == (RW'(h_eff) + RW'(1)));
   end

   // Advance the raster position
   always_ff @(posedge clock) begin
      if (reset || size_wr) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept && process) begin
         if (flags.last) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (col_wrap) begin
            col_ff <= '0;
            row_ff <= row_ff + RW'(1);
         end else begin
            col_ff <= CW'(WW'(col_ff) + WW'(1));
         end
      end
   end

   // Hold the step while the line cells read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= accept && process;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && process) begin
         s1_val_ff   <= val;
         s1_col_ff   <= col_ff;
         s1_flags_ff <= flags;
      end
   end

   // Chain of line cells: recent row hands its old pixel to the older row
   bcde_line_cell #(.DEPTH(MAX_WIDTH)) u_cell_recent (
      .clock   (clock),
      .rd_en   (accept && process),
      .rd_addr (col_ff),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (s1_val_ff),
      .rd_data (mid_old)
   );

   bcde_line_cell #(.DEPTH(MAX_WIDTH)) u_cell_older (
      .clock   (clock),
      .rd_en   (accept && process),
      .rd_addr (col_ff),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (mid_old),
      .rd_data (up_old)
   );

   bcde_window u_window (
      .clock        (clock),
      .reset        (reset),
      .restart      (size_wr),
      .adv          (s1_adv),
      .flags        (s1_flags_ff),
      .mode         (mode_ff),
      .val          (s1_val_ff),
      .up_old       (up_old),
      .mid_old      (mid_old),
      .result_pixel (win_pixel),
      .frame_last   (win_last)
   );

   // Output register: load a finished result, drop it once taken
   assign out_take = out_valid_ff && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv && s1_flags_ff.has_res) begin
         out_valid_ff <= 1'b1;
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_flags_ff.has_res) begin
         out_pixel_ff <= win_pixel;
         out_last_ff  <= win_last;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.result_pixel = out_pixel_ff;
   assign rsp_if.frame_last   = out_last_ff;

endmodule

// ===== rtl/bcde_line_cell.sv =====
// One line store cell: a row of pixels in a memory with a registered read port,
// a write port and same-address forwarding. Depends on nothing.
`timescale 1ns / 1ps

module bcde_line_cell #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic                     wr_data,
   output logic                     rd_data
);

   logic mem [DEPTH];
   logic mem_q_ff;
   logic byp_ff;
   logic byp_data_ff;
   logic hit;

   assign hit = wr_en && (wr_addr == rd_addr);

   // Write the pixel handed in by the previous stage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read the column and capture a write to the same column in the same cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff    <= mem[rd_addr];
         byp_ff      <= hit;
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : mem_q_ff;

endmodule

// ===== rtl/bcde_window.sv =====
// Cross stencil window: holds one column of three rows and the pixel left of its
// center, and forms the dilated or eroded pixel. Depends on bcde_pkg.
`timescale 1ns / 1ps

module bcde_window (
   input  logic                clock,
   input  logic                reset,
   input  logic                restart,
   input  logic                adv,
   input  bcde_pkg::flags_type flags,
   input  logic                mode,
   input  logic                val,
   input  logic                up_old,
   input  logic                mid_old,
   output logic                result_pixel,
   output logic                frame_last
);

   logic [2:0] win_cur_ff;
   logic [2:0] win_cur_in;
   logic       win_left_ff;
   logic       win_left_in;
   logic       c_bit, up_bit, dn_bit, lf_bit, rt_bit;

   // Name the neighbors around the center pixel
   assign c_bit  = win_cur_ff[1];
   assign up_bit = win_cur_ff[0];
   assign dn_bit = win_cur_ff[2];
   assign lf_bit = win_left_ff;
   assign rt_bit = mid_old;

   // Combine the in-frame neighbors
   always_comb begin
      case (mode)
         bcde_pkg::MODE_DILATE: begin
            result_pixel = c_bit | (flags.in_up & up_bit) | (flags.in_dn & dn_bit)
                           | (flags.in_lf & lf_bit) | (flags.in_rt & rt_bit);
         end
         bcde_pkg::MODE_ERODE: begin
            result_pixel = c_bit & (~flags.in_up | up_bit) & (~flags.in_dn | dn_bit)
                           & (~flags.in_lf | lf_bit) & (~flags.in_rt | rt_bit);
         end
         default: begin
            result_pixel = 1'b0;
         end
      endcase
   end

   assign frame_last = flags.last;

   // Shift in the new column, clear at the end of a frame or on a restart
   always_comb begin
      win_cur_in  = win_cur_ff;
      win_left_in = win_left_ff;
      if (restart) begin
         win_cur_in  = 3'b000;
         win_left_in = 1'b0;
      end else if (adv) begin
         if (flags.last) begin
            win_cur_in  = 3'b000;
            win_left_in = 1'b0;
         end else begin
            win_cur_in  = {val, mid_old, up_old};
            win_left_in = win_cur_ff[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_cur_ff  <= 3'b000;
         win_left_ff <= 1'b0;
      end else begin
         win_cur_ff  <= win_cur_in;
         win_left_ff <= win_left_in;
      end
   end

endmodule

// ===== rtl/bcde_checker.sv =====
// Port-level checks of the binary cross dilate/erode block and their bind.
// Depends on binary_cross_dilate_erode and its channel interfaces.
`timescale 1ns / 1ps

module bcde_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic result_pixel,
   input logic frame_last,
   input logic pready
);

   // Hold a stalled result transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(result_pixel) && $stable(frame_last))
      else $error("stalled result transaction changed");

   // Take input whenever no result transaction is held
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while the result register is empty");

   // Drain the result channel in reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Configuration port never waits
   assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("configuration port not ready");

endmodule

bind binary_cross_dilate_erode bcde_checker u_bcde_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .result_pixel (rsp_if.result_pixel),
   .frame_last   (rsp_if.frame_last),
   .pready       (pready)
);
